### design/eft_pkg.sv
// ----------------------------------------------------------------------------
// eft_pkg
// shared constants, codes and control types of the emitter frequency table
// ----------------------------------------------------------------------------
package eft_pkg;

	localparam int ENTRIES   = 16;
	localparam int FRAC_BITS = 16;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int ID_W   = 16;
	localparam int TIME_W = 40;
	localparam int FREQ_W = 32;
	localparam int AMP_W  = 16;

	// 1e6 fits in 20 bits
	localparam int NUM_W = 20 + FRAC_BITS;
	localparam logic [NUM_W-1:0] NUMERATOR = NUM_W'(64'd1000000 << FRAC_BITS);
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic latch;
		logic scan;
		logic act;
		logic div_start;
		logic div_commit;
	} dp_cmd_t;

	typedef struct packed {
		logic add;
		logic slot_hit;
		logic hit;
		logic last;
		logic zero;
		logic div_done;
	} dp_stat_t;

endpackage

### design/eft_div.sv
// ----------------------------------------------------------------------------
// eft_div
// restoring divider, one quotient bit per cycle, fixed numerator
// ----------------------------------------------------------------------------
module eft_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [eft_pkg::TIME_W-1:0] den,
	output logic [eft_pkg::NUM_W-1:0]  quo,
	output logic                       done
);
	import eft_pkg::*;

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [NUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	logic [TIME_W:0]   shifted;
	logic              take;
	logic [TIME_W-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, num_q[NUM_W-1]};
		take     = shifted >= {1'b0, den_q};
		rem_next = take ? TIME_W'(shifted - {1'b0, den_q}) : shifted[TIME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			num_q <= NUMERATOR;
		end else if (run_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[NUM_W-2:0], take};
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule

### design/eft_dp.sv
// ----------------------------------------------------------------------------
// eft_dp
// slot storage, id scan, period and frequency datapath, result register
// ----------------------------------------------------------------------------
module eft_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  eft_pkg::dp_cmd_t                 ctl,
	output eft_pkg::dp_stat_t                stat,
	input  logic [1:0]                       cmd,
	input  logic [eft_pkg::ID_W-1:0]         emitter_id,
	input  logic [eft_pkg::TIME_W-1:0]       contact_time,
	input  logic signed [eft_pkg::AMP_W-1:0] amplitude,
	output logic                             done,
	output logic                             found,
	output logic                             freq_known,
	output logic [eft_pkg::FREQ_W-1:0]       frequency,
	output logic signed [eft_pkg::AMP_W-1:0] amplitude_out,
	output logic [eft_pkg::TIME_W-1:0]       last_contact,
	output logic                             dropped_full,
	output logic                             zero_period
);
	import eft_pkg::*;

	cmd_code_t                op_q;
	logic [ID_W-1:0]          id_q;
	logic [TIME_W-1:0]        time_q;
	logic signed [AMP_W-1:0]  amp_q;

	logic [IDX_W-1:0]         ptr_q;
	logic [IDX_W-1:0]         free_q;
	logic                     hit_q;
	logic                     free_found_q;

	logic [ENTRIES-1:0]       slot_valid_q;
	logic [ID_W-1:0]          slot_id_q    [ENTRIES];
	logic [TIME_W-1:0]        slot_time_q  [ENTRIES];
	logic [FREQ_W-1:0]        slot_freq_q  [ENTRIES];
	logic                     slot_known_q [ENTRIES];
	logic signed [AMP_W-1:0]  slot_amp_q   [ENTRIES];

	logic                     res_valid_q;
	logic                     res_found_q;
	logic                     res_known_q;
	logic [FREQ_W-1:0]        res_freq_q;
	logic signed [AMP_W-1:0]  res_amp_q;
	logic [TIME_W-1:0]        res_time_q;
	logic                     res_drop_q;
	logic                     res_zero_q;

	logic                     slot_hit;
	logic [TIME_W-1:0]        period;
	logic [NUM_W-1:0]         quo;
	logic                     div_done;
	logic [FREQ_W-1:0]        quo_sat;

	assign slot_hit = slot_valid_q[ptr_q] && (slot_id_q[ptr_q] == id_q);
	assign period   = time_q - slot_time_q[ptr_q];
	assign quo_sat  = ((quo >> FREQ_W) != '0) ? '1 : FREQ_W'(quo);

	eft_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.den    (period),
		.quo    (quo),
		.done   (div_done)
	);

	always_comb begin
		stat.add      = (op_q == CMD_ADD);
		stat.slot_hit = slot_hit;
		stat.hit      = hit_q;
		stat.last     = (ptr_q == LAST_IDX);
		stat.zero     = (period == '0);
		stat.div_done = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			free_q       <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			slot_valid_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (ctl.latch) begin
				ptr_q        <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else if (ctl.scan) begin
				if (slot_hit) begin
					hit_q <= 1'b1;
				end else begin
					if (!slot_valid_q[ptr_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= ptr_q;
					end
					if (ptr_q != LAST_IDX) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
			end
			if (ctl.act) begin
				priority if (op_q == CMD_ADD && !hit_q && free_found_q) begin
					slot_valid_q[free_q] <= 1'b1;
				end else if (op_q == CMD_REMOVE && hit_q) begin
					slot_valid_q[ptr_q] <= 1'b0;
				end else if (op_q == CMD_CLEAR) begin
					slot_valid_q <= '0;
				end else begin
				end
			end
			res_valid_q <= ctl.act || ctl.div_commit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			op_q   <= cmd_code_t'(cmd);
			id_q   <= emitter_id;
			time_q <= contact_time;
			amp_q  <= amplitude;
		end

		// zero period on a known id
		if (ctl.act && op_q == CMD_ADD && hit_q) begin
			slot_time_q[ptr_q]  <= time_q;
			slot_amp_q[ptr_q]   <= amp_q;
			slot_freq_q[ptr_q]  <= '1;
			slot_known_q[ptr_q] <= 1'b1;
		end else if (ctl.act && op_q == CMD_ADD && free_found_q) begin
			slot_id_q[free_q]    <= id_q;
			slot_time_q[free_q]  <= time_q;
			slot_amp_q[free_q]   <= amp_q;
			slot_freq_q[free_q]  <= '0;
			slot_known_q[free_q] <= 1'b0;
		end else if (ctl.div_commit) begin
			slot_time_q[ptr_q]  <= time_q;
			slot_amp_q[ptr_q]   <= amp_q;
			slot_freq_q[ptr_q]  <= quo_sat;
			slot_known_q[ptr_q] <= 1'b1;
		end

		if (ctl.act) begin
			res_drop_q <= 1'b0;
			res_zero_q <= 1'b0;
			priority if (op_q == CMD_ADD && hit_q) begin
				res_found_q <= 1'b1;
				res_known_q <= 1'b1;
				res_freq_q  <= '1;
				res_amp_q   <= amp_q;
				res_time_q  <= time_q;
				res_zero_q  <= 1'b1;
			end else if (op_q == CMD_ADD && free_found_q) begin
				res_found_q <= 1'b0;
				res_known_q <= 1'b0;
				res_freq_q  <= '0;
				res_amp_q   <= amp_q;
				res_time_q  <= time_q;
			end else if (op_q == CMD_ADD) begin
				res_found_q <= 1'b0;
				res_known_q <= 1'b0;
				res_freq_q  <= '0;
				res_amp_q   <= '0;
				res_time_q  <= '0;
				res_drop_q  <= 1'b1;
			end else if (hit_q) begin
				res_found_q <= 1'b1;
				res_known_q <= slot_known_q[ptr_q];
				res_freq_q  <= slot_known_q[ptr_q] ? slot_freq_q[ptr_q] : '0;
				res_amp_q   <= slot_amp_q[ptr_q];
				res_time_q  <= slot_time_q[ptr_q];
			end else begin
				res_found_q <= 1'b0;
				res_known_q <= 1'b0;
				res_freq_q  <= '0;
				res_amp_q   <= '0;
				res_time_q  <= '0;
			end
		end else if (ctl.div_commit) begin
			res_found_q <= 1'b1;
			res_known_q <= 1'b1;
			res_freq_q  <= quo_sat;
			res_amp_q   <= amp_q;
			res_time_q  <= time_q;
			res_drop_q  <= 1'b0;
			res_zero_q  <= 1'b0;
		end
	end

	assign done          = res_valid_q;
	assign found         = res_found_q;
	assign freq_known    = res_known_q;
	assign frequency     = res_freq_q;
	assign amplitude_out = res_amp_q;
	assign last_contact  = res_time_q;
	assign dropped_full  = res_drop_q;
	assign zero_period   = res_zero_q;

endmodule

### design/eft_ctrl.sv
// ----------------------------------------------------------------------------
// eft_ctrl
// command sequencer: latch, slot scan, action, frequency division
// ----------------------------------------------------------------------------
module eft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output eft_pkg::dp_cmd_t  ctl,
	input  eft_pkg::dp_stat_t stat
);
	import eft_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.slot_hit || stat.last) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				if (stat.add && stat.hit && !stat.zero) begin
					ctl.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					ctl.act = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					ctl.div_commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### design/emitter_frequency_table.sv
// ----------------------------------------------------------------------------
// emitter_frequency_table
// emitter table with per-id contact time, amplitude and measured frequency
//
//   channel   handshake        beat fields
//   input     start & !busy    cmd, emitter_id, contact_time, amplitude
//   result    done (strobe)    found, freq_known, frequency, amplitude_out,
//                              last_contact, dropped_full, zero_period
//
// one item at a time: a latch step, a scan of the slots (one slot per
// cycle), an action step, then the result strobe in the following cycle
// an add to a known id with nonzero period runs the bit-serial divider in
// place of the action step (36 quotient bits at the default scaling)
// asynchronous reset empties the table at once; no clearing pass
// results are shown for one cycle only and cannot be held off
// ----------------------------------------------------------------------------
module emitter_frequency_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       cmd,
	input  logic [eft_pkg::ID_W-1:0]         emitter_id,
	input  logic [eft_pkg::TIME_W-1:0]       contact_time,
	input  logic signed [eft_pkg::AMP_W-1:0] amplitude,
	output logic                             done,
	output logic                             found,
	output logic                             freq_known,
	output logic [eft_pkg::FREQ_W-1:0]       frequency,
	output logic signed [eft_pkg::AMP_W-1:0] amplitude_out,
	output logic [eft_pkg::TIME_W-1:0]       last_contact,
	output logic                             dropped_full,
	output logic                             zero_period
);
	import eft_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	eft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.stat   (stat)
	);

	eft_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.emitter_id    (emitter_id),
		.contact_time  (contact_time),
		.amplitude     (amplitude),
		.done          (done),
		.found         (found),
		.freq_known    (freq_known),
		.frequency     (frequency),
		.amplitude_out (amplitude_out),
		.last_contact  (last_contact),
		.dropped_full  (dropped_full),
		.zero_period   (zero_period)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && dropped_full |-> !found && !freq_known && !zero_period)
		else $error("dropped insert reports entry data");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_period |-> found && freq_known && (frequency == '1))
		else $error("zero period without saturated frequency");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |-> busy && !done)
		else $error("divider started outside a busy item");

endmodule
